@@ src/axis_angle_vertex_rotate_unit_assert.svh @@
// Assertion macros shared by the vertex rotate unit RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef AXIS_ANGLE_VERTEX_ROTATE_UNIT_ASSERT_SVH
`define AXIS_ANGLE_VERTEX_ROTATE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define AAVR_ASSERT_NOW(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define AAVR_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

@@ src/aavr_pkg.sv @@
// Shared constants, types and helper functions for the vertex rotate unit.
// No dependencies.
package aavr_pkg;

   localparam int UNIT_FRAC  = 14;
   localparam int RAD_WIDTH  = 64;
   localparam int SQRT_STEPS = 32;
   localparam int ROOT_WIDTH = 32;
   localparam int DIV_STEPS  = 16;
   localparam int NUM_WIDTH  = 48;
   localparam int UNIT_WIDTH = 16;
   localparam int SC_WIDTH   = 16;
   localparam int TRIG_WIDTH = 34;
   localparam int MAT_WIDTH  = 48;
   localparam int MR_WIDTH   = 34;
   localparam int CORDIC_MAX = 24;

   localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;
   localparam logic signed [TRIG_WIDTH-1:0] TRIG_ONE = TRIG_WIDTH'(16384);

   typedef struct packed {
      logic valid;
      logic zero;
   } stage_ctl_type;

   // Arctangent of 2^-i in units of 2^-32 turn.
   function automatic logic [31:0] atan_turn(input logic [4:0] idx);
      logic [31:0] res;
      unique case (idx)
         5'd0:    res = 32'h20000000;
         5'd1:    res = 32'h12E4051E;
         5'd2:    res = 32'h09FB385B;
         5'd3:    res = 32'h051111D4;
         5'd4:    res = 32'h028B0D43;
         5'd5:    res = 32'h0145D7E1;
         5'd6:    res = 32'h00A2F61E;
         5'd7:    res = 32'h00517C55;
         5'd8:    res = 32'h0028BE53;
         5'd9:    res = 32'h00145F2F;
         5'd10:   res = 32'h000A2F98;
         5'd11:   res = 32'h000517CC;
         5'd12:   res = 32'h00028BE6;
         5'd13:   res = 32'h000145F3;
         5'd14:   res = 32'h0000A2FA;
         5'd15:   res = 32'h0000517D;
         5'd16:   res = 32'h000028BE;
         5'd17:   res = 32'h0000145F;
         5'd18:   res = 32'h00000A30;
         5'd19:   res = 32'h00000518;
         5'd20:   res = 32'h0000028C;
         5'd21:   res = 32'h00000146;
         5'd22:   res = 32'h000000A3;
         5'd23:   res = 32'h00000051;
         default: res = 32'h00000000;
      endcase
      return res;
   endfunction

   // Round a Q1.30 CORDIC output to Q1.14 and clamp to plus or minus one.
   function automatic logic signed [SC_WIDTH-1:0] trig_round(
         input logic signed [TRIG_WIDTH-1:0] v);
      logic signed [TRIG_WIDTH-1:0] t;
      t = (v + TRIG_WIDTH'(32768)) >>> 16;
      if (t > TRIG_ONE) begin
         t = TRIG_ONE;
      end else if (t < -TRIG_ONE) begin
         t = -TRIG_ONE;
      end
      return SC_WIDTH'(t);
   endfunction

endpackage

@@ src/axis_angle_vertex_rotate_unit.sv @@
// Register stages from request to response: 1 squares, 32 square root,
// 1 + 16 divide, 5 matrix; a new request is taken every cycle unless a response is stalled.
// The whole pipeline advances whenever the response register is empty or read.
// Reset (synchronous, active high) clears every stage valid; data is not reset.
// Depends on aavr_pkg, aavr_norm_trig, aavr_div, aavr_matrix and the assert header.
`include "axis_angle_vertex_rotate_unit_assert.svh"
module axis_angle_vertex_rotate_unit
   import aavr_pkg::*;
#(
   parameter int COORD_WIDTH = 24,
   parameter int AXIS_WIDTH  = 16,
   parameter int TRIG_STEPS  = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // axis_x, axis_y, axis_z, angle[15:0], vert_x, vert_y, vert_z, zero pad
   input  logic [((3*AXIS_WIDTH+16+3*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // rot_x, rot_y, rot_z, zero pad
   output logic [((3*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // axis_zero
   output logic rsp_tuser
);

   localparam int RSP_W = ((3 * COORD_WIDTH + 7) / 8) * 8;
   localparam int ANG_LO = 3 * AXIS_WIDTH;
   localparam int VRT_LO = ANG_LO + 16;

   logic advance;
   logic signed [AXIS_WIDTH-1:0]  ax_x, ax_y, ax_z;
   logic signed [COORD_WIDTH-1:0] vx, vy, vz;

   stage_ctl_type                 nt_ctl, dv_ctl, mx_ctl;
   logic [ROOT_WIDTH-1:0]         nt_root;
   logic signed [AXIS_WIDTH-1:0]  nt_ax [0:2];
   logic signed [SC_WIDTH-1:0]    nt_sin, nt_cos, dv_sin, dv_cos;
   logic signed [COORD_WIDTH-1:0] nt_vert [0:2];
   logic signed [COORD_WIDTH-1:0] dv_vert [0:2];
   logic signed [UNIT_WIDTH-1:0]  dv_unit [0:2];
   logic signed [COORD_WIDTH-1:0] mx_rot [0:2];

   // Hold every stage while a response waits.
   assign advance    = !mx_ctl.valid || rsp_tready;
   assign req_tready = advance;

   assign ax_x = req_tdata[AXIS_WIDTH-1:0];
   assign ax_y = req_tdata[2*AXIS_WIDTH-1:AXIS_WIDTH];
   assign ax_z = req_tdata[3*AXIS_WIDTH-1:2*AXIS_WIDTH];
   assign vx   = req_tdata[VRT_LO+COORD_WIDTH-1:VRT_LO];
   assign vy   = req_tdata[VRT_LO+2*COORD_WIDTH-1:VRT_LO+COORD_WIDTH];
   assign vz   = req_tdata[VRT_LO+3*COORD_WIDTH-1:VRT_LO+2*COORD_WIDTH];

   aavr_norm_trig #(
      .AXIS_WIDTH (AXIS_WIDTH),
      .COORD_WIDTH(COORD_WIDTH),
      .TRIG_STEPS (TRIG_STEPS)
   ) u_norm_trig (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_valid(req_tvalid),
      .axis_x  (ax_x),
      .axis_y  (ax_y),
      .axis_z  (ax_z),
      .angle   (req_tdata[ANG_LO+15:ANG_LO]),
      .vert_x  (vx),
      .vert_y  (vy),
      .vert_z  (vz),
      .ctl_out (nt_ctl),
      .root    (nt_root),
      .ax_out  (nt_ax),
      .sin_val (nt_sin),
      .cos_val (nt_cos),
      .vert_out(nt_vert)
   );

   aavr_div #(
      .AXIS_WIDTH (AXIS_WIDTH),
      .COORD_WIDTH(COORD_WIDTH)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .ctl_in  (nt_ctl),
      .root    (nt_root),
      .ax_in   (nt_ax),
      .sin_in  (nt_sin),
      .cos_in  (nt_cos),
      .vert_in (nt_vert),
      .ctl_out (dv_ctl),
      .unit    (dv_unit),
      .sin_out (dv_sin),
      .cos_out (dv_cos),
      .vert_out(dv_vert)
   );

   aavr_matrix #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_matrix (
      .clock  (clock),
      .reset  (reset),
      .advance(advance),
      .ctl_in (dv_ctl),
      .unit   (dv_unit),
      .sin_in (dv_sin),
      .cos_in (dv_cos),
      .vert_in(dv_vert),
      .ctl_out(mx_ctl),
      .rot    (mx_rot)
   );

   assign rsp_tvalid = mx_ctl.valid;
   assign rsp_tdata  = RSP_W'({mx_rot[2], mx_rot[1], mx_rot[0]});
   assign rsp_tuser  = mx_ctl.zero;

   `AAVR_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata),
      "response changed while stalled")
   `AAVR_ASSERT_NOW(a_root_nonzero, clock, reset,
      nt_ctl.valid && !nt_ctl.zero, nt_root != '0, "nonzero axis gave zero root")
   `AAVR_ASSERT_NOW(a_root_zero, clock, reset,
      nt_ctl.valid && nt_ctl.zero, nt_root == '0, "zero axis gave nonzero root")
   `AAVR_ASSERT_NEXT(a_stall_freeze, clock, reset,
      !advance, $stable(dv_ctl) && $stable(nt_ctl), "pipeline moved during stall")

endmodule

@@ src/aavr_norm_trig.sv @@
// Axis length (sum of squares plus digit-serial square root, one bit a stage)
// and CORDIC sine/cosine running alongside. Depends on aavr_pkg.
module aavr_norm_trig
   import aavr_pkg::*;
#(
   parameter int AXIS_WIDTH  = 16,
   parameter int COORD_WIDTH = 24,
   parameter int TRIG_STEPS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic signed [AXIS_WIDTH-1:0]  axis_x,
   input  logic signed [AXIS_WIDTH-1:0]  axis_y,
   input  logic signed [AXIS_WIDTH-1:0]  axis_z,
   input  logic [15:0]                   angle,
   input  logic signed [COORD_WIDTH-1:0] vert_x,
   input  logic signed [COORD_WIDTH-1:0] vert_y,
   input  logic signed [COORD_WIDTH-1:0] vert_z,
   output stage_ctl_type                 ctl_out,
   output logic [ROOT_WIDTH-1:0]         root,
   output logic signed [AXIS_WIDTH-1:0]  ax_out [0:2],
   output logic signed [SC_WIDTH-1:0]    sin_val,
   output logic signed [SC_WIDTH-1:0]    cos_val,
   output logic signed [COORD_WIDTH-1:0] vert_out [0:2]
);

   localparam int N2W = 2 * AXIS_WIDTH;
   localparam int SHIFT2 = RAD_WIDTH - N2W;

   logic                          valid_ff [0:SQRT_STEPS];
   logic                          zero_ff  [0:SQRT_STEPS];
   logic [RAD_WIDTH-1:0]          rad_ff   [0:SQRT_STEPS];
   logic [RAD_WIDTH-1:0]          root_ff  [0:SQRT_STEPS];
   logic signed [AXIS_WIDTH-1:0]  ax_ff    [0:SQRT_STEPS][0:2];
   logic signed [COORD_WIDTH-1:0] v_ff     [0:SQRT_STEPS][0:2];
   logic [1:0]                    quad_ff  [0:SQRT_STEPS];
   logic signed [TRIG_WIDTH-1:0]  cx_ff    [0:SQRT_STEPS];
   logic signed [TRIG_WIDTH-1:0]  cy_ff    [0:SQRT_STEPS];
   logic signed [TRIG_WIDTH-1:0]  cz_ff    [0:SQRT_STEPS];

   logic signed [N2W-1:0] sqx, sqy, sqz;
   logic [N2W-1:0]        n2_in;

   assign sqx   = axis_x * axis_x;
   assign sqy   = axis_y * axis_y;
   assign sqz   = axis_z * axis_z;
   assign n2_in = unsigned'(sqx) + unsigned'(sqy) + unsigned'(sqz);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         zero_ff[0]  <= (n2_in == '0);
         rad_ff[0]   <= RAD_WIDTH'(n2_in) << SHIFT2;
         root_ff[0]  <= '0;
         ax_ff[0][0] <= axis_x;
         ax_ff[0][1] <= axis_y;
         ax_ff[0][2] <= axis_z;
         v_ff[0][0]  <= vert_x;
         v_ff[0][1]  <= vert_y;
         v_ff[0][2]  <= vert_z;
         quad_ff[0]  <= angle[15:14];
         cx_ff[0]    <= TRIG_WIDTH'(CORDIC_GAIN);
         cy_ff[0]    <= '0;
         cz_ff[0]    <= TRIG_WIDTH'({angle[13:0], 16'h0000});
      end
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam logic [RAD_WIDTH-1:0] BIT = RAD_WIDTH'(1) << (RAD_WIDTH - 2 - 2 * k);
      logic [RAD_WIDTH-1:0]         trial;
      logic                         take;
      logic signed [TRIG_WIDTH-1:0] cx_in, cy_in, cz_in;

      assign trial = root_ff[k] + BIT;
      assign take  = (rad_ff[k] >= trial);

      if (k < TRIG_STEPS && k < CORDIC_MAX) begin : g_cordic
         logic signed [TRIG_WIDTH-1:0] dx, dy, at;
         assign dx = cy_ff[k] >>> k;
         assign dy = cx_ff[k] >>> k;
         assign at = TRIG_WIDTH'(atan_turn(5'(k)));
         always_comb begin
            if (!cz_ff[k][TRIG_WIDTH-1]) begin
               cx_in = cx_ff[k] - dx;
               cy_in = cy_ff[k] + dy;
               cz_in = cz_ff[k] - at;
            end else begin
               cx_in = cx_ff[k] + dx;
               cy_in = cy_ff[k] - dy;
               cz_in = cz_ff[k] + at;
            end
         end
      end else begin : g_hold
         assign cx_in = cx_ff[k];
         assign cy_in = cy_ff[k];
         assign cz_in = cz_ff[k];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            zero_ff[k+1] <= zero_ff[k];
            rad_ff[k+1]  <= take ? rad_ff[k] - trial : rad_ff[k];
            root_ff[k+1] <= take ? (root_ff[k] >> 1) + BIT : root_ff[k] >> 1;
            for (int i = 0; i < 3; i++) begin
               ax_ff[k+1][i] <= ax_ff[k][i];
               v_ff[k+1][i]  <= v_ff[k][i];
            end
            quad_ff[k+1] <= quad_ff[k];
            cx_ff[k+1]   <= cx_in;
            cy_ff[k+1]   <= cy_in;
            cz_ff[k+1]   <= cz_in;
         end
      end
   end

   logic signed [SC_WIDTH-1:0] cs_r, sn_r;

   assign cs_r = trig_round(cx_ff[SQRT_STEPS]);
   assign sn_r = trig_round(cy_ff[SQRT_STEPS]);

   // Fold the quadrant back in.
   always_comb begin
      unique case (quad_ff[SQRT_STEPS])
         2'd1: begin
            cos_val = -sn_r;
            sin_val = cs_r;
         end
         2'd2: begin
            cos_val = -cs_r;
            sin_val = -sn_r;
         end
         2'd3: begin
            cos_val = sn_r;
            sin_val = -cs_r;
         end
         default: begin
            cos_val = cs_r;
            sin_val = sn_r;
         end
      endcase
   end

   assign ctl_out.valid = valid_ff[SQRT_STEPS];
   assign ctl_out.zero  = zero_ff[SQRT_STEPS];
   assign root          = root_ff[SQRT_STEPS][ROOT_WIDTH-1:0];
   assign ax_out        = ax_ff[SQRT_STEPS];
   assign vert_out      = v_ff[SQRT_STEPS];

endmodule

@@ src/aavr_div.sv @@
// Restoring division, one quotient bit a stage, for the three unit axis
// components. Depends on aavr_pkg.
module aavr_div
   import aavr_pkg::*;
#(
   parameter int AXIS_WIDTH  = 16,
   parameter int COORD_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  stage_ctl_type                 ctl_in,
   input  logic [ROOT_WIDTH-1:0]         root,
   input  logic signed [AXIS_WIDTH-1:0]  ax_in [0:2],
   input  logic signed [SC_WIDTH-1:0]    sin_in,
   input  logic signed [SC_WIDTH-1:0]    cos_in,
   input  logic signed [COORD_WIDTH-1:0] vert_in [0:2],
   output stage_ctl_type                 ctl_out,
   output logic signed [UNIT_WIDTH-1:0]  unit [0:2],
   output logic signed [SC_WIDTH-1:0]    sin_out,
   output logic signed [SC_WIDTH-1:0]    cos_out,
   output logic signed [COORD_WIDTH-1:0] vert_out [0:2]
);

   localparam int NUM_SHIFT = UNIT_FRAC + 32 - AXIS_WIDTH;
   localparam logic [DIV_STEPS-1:0] Q_ONE = DIV_STEPS'(1) << UNIT_FRAC;

   logic                          valid_ff [0:DIV_STEPS];
   logic                          zero_ff  [0:DIV_STEPS];
   logic [ROOT_WIDTH-1:0]         den_ff   [0:DIV_STEPS];
   logic [NUM_WIDTH-1:0]          rem_ff   [0:DIV_STEPS][0:2];
   logic [DIV_STEPS-1:0]          quo_ff   [0:DIV_STEPS][0:2];
   logic                          neg_ff   [0:DIV_STEPS][0:2];
   logic signed [SC_WIDTH-1:0]    sin_ff   [0:DIV_STEPS];
   logic signed [SC_WIDTH-1:0]    cos_ff   [0:DIV_STEPS];
   logic signed [COORD_WIDTH-1:0] v_ff     [0:DIV_STEPS][0:2];

   logic [AXIS_WIDTH-1:0] mag [0:2];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag[i] = ax_in[i][AXIS_WIDTH-1] ? unsigned'(-ax_in[i]) : unsigned'(ax_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= ctl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         zero_ff[0] <= ctl_in.zero;
         den_ff[0]  <= root;
         sin_ff[0]  <= sin_in;
         cos_ff[0]  <= cos_in;
         for (int i = 0; i < 3; i++) begin
            rem_ff[0][i] <= (NUM_WIDTH'(mag[i]) << NUM_SHIFT) + NUM_WIDTH'(root >> 1);
            quo_ff[0][i] <= '0;
            neg_ff[0][i] <= ax_in[i][AXIS_WIDTH-1];
            v_ff[0][i]   <= vert_in[i];
         end
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      localparam int QB = DIV_STEPS - 1 - k;
      logic [NUM_WIDTH-1:0] dsh;

      assign dsh = NUM_WIDTH'(den_ff[k]) << QB;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            zero_ff[k+1] <= zero_ff[k];
            den_ff[k+1]  <= den_ff[k];
            sin_ff[k+1]  <= sin_ff[k];
            cos_ff[k+1]  <= cos_ff[k];
            for (int i = 0; i < 3; i++) begin
               if (rem_ff[k][i] >= dsh) begin
                  rem_ff[k+1][i] <= rem_ff[k][i] - dsh;
                  quo_ff[k+1][i] <= quo_ff[k][i] | (DIV_STEPS'(1) << QB);
               end else begin
                  rem_ff[k+1][i] <= rem_ff[k][i];
                  quo_ff[k+1][i] <= quo_ff[k][i];
               end
               neg_ff[k+1][i] <= neg_ff[k][i];
               v_ff[k+1][i]   <= v_ff[k][i];
            end
         end
      end
   end

   // Clamp rounding overshoot to one, then restore the sign.
   always_comb begin
      logic [DIV_STEPS-1:0] q;
      for (int i = 0; i < 3; i++) begin
         q = (quo_ff[DIV_STEPS][i] > Q_ONE) ? Q_ONE : quo_ff[DIV_STEPS][i];
         unit[i] = neg_ff[DIV_STEPS][i] ? -signed'(UNIT_WIDTH'(q)) : signed'(UNIT_WIDTH'(q));
      end
   end

   assign ctl_out.valid = valid_ff[DIV_STEPS];
   assign ctl_out.zero  = zero_ff[DIV_STEPS];
   assign sin_out       = sin_ff[DIV_STEPS];
   assign cos_out       = cos_ff[DIV_STEPS];
   assign vert_out      = v_ff[DIV_STEPS];

endmodule

@@ src/aavr_matrix.sv @@
// Rodrigues matrix build and matrix-vector product with rounding and
// saturation, five register stages. Depends on aavr_pkg.
module aavr_matrix
   import aavr_pkg::*;
#(
   parameter int COORD_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  stage_ctl_type                 ctl_in,
   input  logic signed [UNIT_WIDTH-1:0]  unit [0:2],
   input  logic signed [SC_WIDTH-1:0]    sin_in,
   input  logic signed [SC_WIDTH-1:0]    cos_in,
   input  logic signed [COORD_WIDTH-1:0] vert_in [0:2],
   output stage_ctl_type                 ctl_out,
   output logic signed [COORD_WIDTH-1:0] rot [0:2]
);

   localparam int UU_W  = 2 * UNIT_WIDTH;
   localparam int AC_W  = SC_WIDTH + 2;
   localparam int P_W   = COORD_WIDTH + MR_WIDTH;
   localparam int ACC_W = P_W + 2;
   localparam logic signed [ACC_W-1:0] SAT_HI =
      ACC_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

   logic [4:0]                    valid_ff;
   logic                          zero_ff [0:4];
   logic signed [COORD_WIDTH-1:0] v_ff    [0:3][0:2];

   logic signed [UU_W-1:0]      uu_ff [0:2][0:2];
   logic signed [UU_W-1:0]      su_ff [0:2];
   logic signed [AC_W-1:0]      ac_ff;
   logic signed [SC_WIDTH-1:0]  c_ff;
   logic signed [MAT_WIDTH-1:0] m_ff  [0:2][0:2];
   logic signed [MR_WIDTH-1:0]  mr_ff [0:2][0:2];
   logic signed [P_W-1:0]       p_ff  [0:2][0:2];
   logic signed [COORD_WIDTH-1:0] rot_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[3:0], ctl_in.valid};
      end
   end

   // Stage A: axis outer product and sine terms.
   always_ff @(posedge clock) begin
      if (advance) begin
         zero_ff[0] <= ctl_in.zero;
         ac_ff      <= AC_W'(16384) - AC_W'(cos_in);
         c_ff       <= cos_in;
         for (int i = 0; i < 3; i++) begin
            v_ff[0][i]  <= vert_in[i];
            su_ff[i]    <= UU_W'(sin_in) * UU_W'(unit[i]);
            for (int j = 0; j < 3; j++) begin
               uu_ff[i][j] <= UU_W'(unit[i]) * UU_W'(unit[j]);
            end
         end
      end
   end

   // Stage B: matrix entries in Q42.
   for (genvar i = 0; i < 3; i++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
         localparam int K = 3 - i - j;
         logic signed [AC_W+UU_W-1:0] prod;
         logic signed [MAT_WIDTH-1:0] term;
         logic signed [MAT_WIDTH-1:0] m_in;

         assign prod = ac_ff * uu_ff[i][j];
         if (i == j) begin : g_diag
            assign term = MAT_WIDTH'(c_ff) <<< 28;
         end else if (j == (i + 2) % 3) begin : g_plus
            assign term = MAT_WIDTH'(su_ff[K]) <<< UNIT_FRAC;
         end else begin : g_minus
            assign term = -(MAT_WIDTH'(su_ff[K]) <<< UNIT_FRAC);
         end
         assign m_in = MAT_WIDTH'(prod) + term;

         always_ff @(posedge clock) begin
            if (advance) begin
               m_ff[i][j]  <= m_in;
               mr_ff[i][j] <= MR_WIDTH'((m_ff[i][j] + MAT_WIDTH'(8192)) >>> 14);
               p_ff[i][j]  <= P_W'(v_ff[2][j]) * P_W'(mr_ff[i][j]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 1; s < 5; s++) begin
            zero_ff[s] <= zero_ff[s-1];
         end
         for (int s = 1; s < 4; s++) begin
            v_ff[s] <= v_ff[s-1];
         end
      end
   end

   // Stage E: sum, round, saturate; a zero axis passes the vertex through.
   always_ff @(posedge clock) begin
      logic signed [ACC_W-1:0] acc;
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            acc = ACC_W'(p_ff[i][0]) + ACC_W'(p_ff[i][1]) + ACC_W'(p_ff[i][2])
                  + ACC_W'(134217728);
            acc = acc >>> 28;
            if (zero_ff[3]) begin
               rot_ff[i] <= v_ff[3][i];
            end else if (acc > SAT_HI) begin
               rot_ff[i] <= COORD_WIDTH'(SAT_HI);
            end else if (acc < SAT_LO) begin
               rot_ff[i] <= COORD_WIDTH'(SAT_LO);
            end else begin
               rot_ff[i] <= COORD_WIDTH'(acc);
            end
         end
      end
   end

   assign ctl_out.valid = valid_ff[4];
   assign ctl_out.zero  = zero_ff[4];
   assign rot           = rot_ff;

endmodule
